### rtl/core/cbm_pkg.sv
// Shared types, codes, constants and the CPU write decode for the cartridge bank mapper.
package cbm_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_CPU_READ  = 3'd1,
        OP_CPU_WRITE = 3'd2,
        OP_PPU_READ  = 3'd3,
        OP_PPU_WRITE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_PRG  = 2'd1,
        TGT_CHR  = 2'd2,
        TGT_NT   = 2'd3
    } tgt_t;

    typedef enum logic [3:0] {
        WR_NONE,
        WR_PRG0,
        WR_PRG1,
        WR_CHR0,
        WR_CHR1,
        WR_CHR2,
        WR_CHR3,
        WR_CHR4,
        WR_CHR5,
        WR_IRQ_LATCH,
        WR_IRQ_CLEAR,
        WR_IRQ_ENABLE,
        WR_IRQ_DISABLE,
        WR_MIRROR
    } wr_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] address;
        logic [7:0]  data;
    } req_t;

    typedef struct packed {
        logic            mirror;
        logic [1:0][5:0] prg;
        logic [5:0][7:0] chr;
    } bank_state_t;

    localparam logic [5:0] PRG_FIXED_LOW  = 6'h3e;
    localparam logic [5:0] PRG_FIXED_HIGH = 6'h3f;
    localparam logic [2:0] FILTER_TICKS   = 3'd6;
    localparam logic [2:0] LINE_TICKS     = 3'd6;

    // address & 0xe003 decode, only at 0x8000 and above
    function automatic wr_t decode_write(input logic [15:0] addr);
        wr_t code;
        code = WR_NONE;
        if (addr[15])
        begin
            case ({addr[14:13], addr[1:0]})
                4'b0000: code = WR_PRG0;
                4'b0001: code = WR_PRG1;
                4'b0010: code = WR_CHR0;
                4'b0011: code = WR_CHR1;
                4'b0100: code = WR_CHR2;
                4'b0101: code = WR_CHR3;
                4'b0110: code = WR_CHR4;
                4'b0111: code = WR_CHR5;
                4'b1000: code = WR_IRQ_LATCH;
                4'b1001: code = WR_IRQ_CLEAR;
                4'b1010: code = WR_IRQ_ENABLE;
                4'b1011: code = WR_IRQ_DISABLE;
                4'b1100: code = WR_MIRROR;
                default: code = WR_NONE;
            endcase
        end
        return code;
    endfunction

endpackage

### rtl/core/cbm_regs.sv
// Program bank, character bank and mirroring registers written by CPU requests.
module cbm_regs
    import cbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  req_t        req,
    output bank_state_t banks
);

    bank_state_t banks_reg;
    bank_state_t banks_next;

    always_comb
    begin
        banks_next = banks_reg;
        if (fire && (req.operation == OP_CPU_WRITE))
        begin
            case (decode_write(req.address))
                WR_PRG0:   banks_next.prg[0] = req.data[5:0];
                WR_PRG1:   banks_next.prg[1] = req.data[5:0];
                WR_CHR0:   banks_next.chr[0] = req.data;
                WR_CHR1:   banks_next.chr[1] = req.data;
                WR_CHR2:   banks_next.chr[2] = req.data;
                WR_CHR3:   banks_next.chr[3] = req.data;
                WR_CHR4:   banks_next.chr[4] = req.data;
                WR_CHR5:   banks_next.chr[5] = req.data;
                WR_MIRROR: banks_next.mirror = req.data[6];
                default:   banks_next = banks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            banks_reg <= '0;
        end
        else
        begin
            banks_reg <= banks_next;
        end
    end

    assign banks = banks_reg;

endmodule

### rtl/core/cbm_irq.sv
// Scanline counter: A12 edge filter, down-counter, IRQ delay and line level.
module cbm_irq
    import cbm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  req_t req,
    output logic irq_level_next
);

    logic [7:0] reload_reg, reload_next;
    logic [7:0] count_reg, count_next;
    logic       enabled_reg, enabled_next;
    logic [2:0] filter_reg, filter_next;
    logic [2:0] delay_reg, delay_next;
    logic       level_reg, level_next;
    logic       last_a12_reg, last_a12_next;

    always_comb
    begin
        logic [7:0] loaded;
        logic [7:0] counted;
        reload_next   = reload_reg;
        count_next    = count_reg;
        enabled_next  = enabled_reg;
        filter_next   = filter_reg;
        delay_next    = delay_reg;
        level_next    = level_reg;
        last_a12_next = last_a12_reg;
        loaded  = (count_reg == 8'd0) ? (reload_reg + 8'd1) : count_reg;
        counted = loaded - 8'd1;
        if (fire)
        begin
            case (req.operation)
                OP_TICK:
                begin
                    if (filter_reg != 3'd0)
                        filter_next = filter_reg - 3'd1;
                    if (delay_reg != 3'd0)
                    begin
                        delay_next = delay_reg - 3'd1;
                        if (delay_reg == 3'd1)
                            level_next = 1'b1;
                    end
                end
                OP_CPU_WRITE:
                begin
                    case (decode_write(req.address))
                        WR_IRQ_LATCH:   reload_next = ~req.data;
                        WR_IRQ_CLEAR:   count_next = 8'd0;
                        WR_IRQ_ENABLE:  enabled_next = 1'b1;
                        WR_IRQ_DISABLE:
                        begin
                            enabled_next = 1'b0;
                            level_next   = 1'b0;
                        end
                        default:        reload_next = reload_reg;
                    endcase
                end
                OP_PPU_READ, OP_PPU_WRITE:
                begin
                    if (!last_a12_reg && req.address[12])
                    begin
                        // edge inside the filter window only re-arms the window
                        if (filter_reg == 3'd0)
                        begin
                            count_next = counted;
                            if ((counted == 8'd0) && enabled_reg)
                                delay_next = LINE_TICKS;
                        end
                        filter_next = FILTER_TICKS;
                    end
                    last_a12_next = req.address[12];
                end
                default: level_next = level_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg   <= 8'd0;
            count_reg    <= 8'd0;
            enabled_reg  <= 1'b0;
            filter_reg   <= 3'd0;
            delay_reg    <= 3'd0;
            level_reg    <= 1'b0;
            last_a12_reg <= 1'b0;
        end
        else
        begin
            reload_reg   <= reload_next;
            count_reg    <= count_next;
            enabled_reg  <= enabled_next;
            filter_reg   <= filter_next;
            delay_reg    <= delay_next;
            level_reg    <= level_next;
            last_a12_reg <= last_a12_next;
        end
    end

    assign irq_level_next = level_next;

endmodule

### rtl/core/cbm_map.sv
// Address translation for CPU and PPU requests.
module cbm_map
    import cbm_pkg::*;
(
    input  req_t        req,
    input  bank_state_t banks,
    output logic [18:0] mapped,
    output tgt_t        target
);

    always_comb
    begin
        logic [5:0] prg_bank;
        logic [2:0] chr_idx;
        logic       nt_page;
        mapped   = 19'd0;
        target   = TGT_NONE;
        prg_bank = PRG_FIXED_HIGH;
        chr_idx  = {1'b0, req.address[11:10]} + 3'd2;
        nt_page  = banks.mirror ? req.address[11] : req.address[10];
        case (req.operation)
            OP_CPU_READ:
            begin
                if (!req.address[15])
                begin
                    // open bus value passes through
                    mapped = {11'd0, req.data};
                end
                else
                begin
                    case (req.address[14:13])
                        2'd0:    prg_bank = banks.prg[0];
                        2'd1:    prg_bank = banks.prg[1];
                        2'd2:    prg_bank = PRG_FIXED_LOW;
                        default: prg_bank = PRG_FIXED_HIGH;
                    endcase
                    mapped = {prg_bank, req.address[12:0]};
                    target = TGT_PRG;
                end
            end
            OP_PPU_READ, OP_PPU_WRITE:
            begin
                if (req.address[13])
                begin
                    mapped = {8'd0, nt_page, req.address[9:0]};
                    target = TGT_NT;
                end
                else if (req.operation == OP_PPU_READ)
                begin
                    if (!req.address[12])
                        mapped = {banks.chr[{2'b00, req.address[11]}], req.address[10:0]};
                    else
                        mapped = {1'b0, banks.chr[chr_idx], req.address[9:0]};
                    target = TGT_CHR;
                end
            end
            default: target = TGT_NONE;
        endcase
    end

endmodule

### rtl/core/cartridge_bank_mapper_with_scanline_irq.sv
// Top level of the cartridge bank mapper with scanline IRQ counter.
// Usage:
//   Request channel (request_valid / request_stall) carries one bus event:
//   operation (tick, CPU read, CPU write, PPU read, PPU write), address and
//   data. Result channel (result_valid / result_stall) returns one result
//   per request: mapped_address, target and irq_line (level after the
//   request's own update).
//   The request register holds the request while decode runs, and the
//   result register takes it as soon as the result slot is free.
//   Throughput: one request per cycle while the result side does not stall,
//   set by the single pass of decode, bank mapping and counter update
//   between those two registers.
//   Stall: when result_stall holds a waiting result, the request register
//   still takes one more request; request_stall rises only while both the
//   request register and the result register are full.
//   Reset: rst_n clears both valid flags, all bank registers, mirroring and
//   the whole IRQ counter, so every switchable bank starts at bank zero.
module cartridge_bank_mapper_with_scanline_irq
    import cbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        request_valid,
    output logic        request_stall,
    input  logic [2:0]  operation,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [18:0] mapped_address,
    output logic [1:0]  target,
    output logic        irq_line
);

    // request stage
    logic        req_valid_reg;
    req_t        req_reg;
    logic        accept;
    logic        advance;

    // result stage
    logic        result_valid_reg;
    logic [18:0] mapped_reg;
    tgt_t        target_reg;
    logic        irq_reg;

    bank_state_t banks;
    logic [18:0] mapped_next;
    tgt_t        target_next;
    logic        irq_next;

    // the request moves on, and state updates, when the result slot is free
    assign advance       = req_valid_reg && (!result_valid_reg || !result_stall);
    assign request_stall = req_valid_reg && !advance;
    assign accept        = request_valid && !request_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.operation <= operation;
            req_reg.address   <= address;
            req_reg.data      <= data;
        end
    end

    cbm_regs u_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (req_reg),
        .banks (banks)
    );

    cbm_irq u_irq
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .req            (req_reg),
        .irq_level_next (irq_next)
    );

    // mapping reads bank state as it stood before this request
    cbm_map u_map
    (
        .req    (req_reg),
        .banks  (banks),
        .mapped (mapped_next),
        .target (target_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mapped_reg <= mapped_next;
            target_reg <= target_next;
            irq_reg    <= irq_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign mapped_address = mapped_reg;
    assign target         = target_reg;
    assign irq_line       = irq_reg;

    // a request that moves on always lands in the result register
    a_advance_fills : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("advanced request did not reach the result register");

    // untranslated results carry at most the open-bus byte
    a_none_narrow : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (target_reg == TGT_NONE)) |-> (mapped_reg[18:8] == 11'd0))
        else $error("pass-through result wider than a byte");

    // nametable RAM is 2 KB
    a_nt_range : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (target_reg == TGT_NT)) |-> (mapped_reg[18:11] == 8'd0))
        else $error("nametable address beyond 2 KB");

endmodule

### bench/testbench.sv
// Self-checking bench for the cartridge bank mapper with scanline IRQ counter.
`timescale 1ns / 100ps

module testbench
    import cbm_pkg::*;
();

    localparam int          STUCK_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int          LONG_HOLD    = 40;    // long result hold-off, in cycles
    localparam int          QUIET_ITEMS  = 100;   // tail of the run with no idling
    localparam int          RANDOM_ITEMS = 625;
    localparam logic [15:0] WRITE_DECODE_MASK = 16'he003;

    // one queued request, with a flag that makes the driver wait for a full drain first
    typedef struct {
        req_t req;
        bit   drain;
    } pending_t;

    // what one request should return
    typedef struct packed {
        logic [18:0] addr;
        logic [1:0]  tgt;
        logic        irq;
    } answer_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        request_valid  = 1'b0;
    logic        request_stall;
    logic [2:0]  operation      = '0;
    logic [15:0] address        = '0;
    logic [7:0]  data           = '0;
    logic        result_valid;
    logic        result_stall   = 1'b0;
    logic [18:0] mapped_address;
    logic [1:0]  target;
    logic        irq_line;

    cartridge_bank_mapper_with_scanline_irq u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_stall  (request_stall),
        .operation      (operation),
        .address        (address),
        .data           (data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .mapped_address (mapped_address),
        .target         (target),
        .irq_line       (irq_line)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mapper state as the bench sees it. Reset happens once, so the
    // declaration values stand in for the post-reset state.
    // ------------------------------------------------------------------
    logic       mirror_sel  = 1'b0;
    logic [5:0] prg_bank [2] = '{default: '0};
    logic [7:0] chr_bank [6] = '{default: '0};
    logic [7:0] irq_latch   = '0;   // already inverted, as the counter reloads from it
    logic [7:0] irq_counter = '0;
    logic       irq_on      = 1'b0;
    logic [2:0] filter_left = '0;   // ticks until another A12 edge may clock the counter
    logic [2:0] line_wait   = '0;   // ticks until the IRQ line rises
    logic       irq_out     = 1'b0;
    logic       prev_a12    = 1'b0;

    pending_t pending [$];
    answer_t  awaited [$];

    int  fails      = 0;
    int  n_launched = 0;    // requests put on the bus (blocking, driver only)
    int  n_sent     = 0;    // requests accepted by the block
    int  n_seen     = 0;    // results accepted from the block
    int  quiet_from = 0;
    bit  drain_next = 1'b0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fails++;
    endtask

    // Advance the bench copy of the mapper by one request and queue the
    // result it should produce.
    task automatic map_bus_event(input req_t r);
        answer_t    ans;
        logic [5:0] bank;
        ans = '0;
        case (r.operation)
            OP_TICK:
            begin
                if (filter_left != 0)
                    filter_left--;
                if (line_wait != 0)
                begin
                    line_wait--;
                    if (line_wait == 0)
                        irq_out = 1'b1;
                end
            end
            OP_CPU_READ:
            begin
                if (!r.address[15])
                    ans.addr = {11'd0, r.data};     // open bus pass-through
                else
                begin
                    case (r.address[14:13])
                        2'd0:    bank = prg_bank[0];
                        2'd1:    bank = prg_bank[1];
                        2'd2:    bank = PRG_FIXED_LOW;
                        default: bank = PRG_FIXED_HIGH;
                    endcase
                    ans.addr = {bank, r.address[12:0]};
                    ans.tgt  = TGT_PRG;
                end
            end
            OP_CPU_WRITE:
            begin
                if (r.address[15])
                begin
                    case (r.address & WRITE_DECODE_MASK)
                        16'h8000: prg_bank[0] = r.data[5:0];
                        16'h8001: prg_bank[1] = r.data[5:0];
                        16'h8002: chr_bank[0] = r.data;
                        16'h8003: chr_bank[1] = r.data;
                        16'ha000: chr_bank[2] = r.data;
                        16'ha001: chr_bank[3] = r.data;
                        16'ha002: chr_bank[4] = r.data;
                        16'ha003: chr_bank[5] = r.data;
                        16'hc000: irq_latch   = ~r.data;
                        16'hc001: irq_counter = '0;
                        16'hc002: irq_on      = 1'b1;
                        16'hc003:
                        begin
                            irq_on  = 1'b0;
                            irq_out = 1'b0;
                        end
                        16'he000: mirror_sel = r.data[6];
                        default: ;
                    endcase
                end
            end
            OP_PPU_READ, OP_PPU_WRITE:
            begin
                // A12 rising edge clocks the counter unless the filter is still open
                if (!prev_a12 && r.address[12])
                begin
                    if (filter_left == 0)
                    begin
                        if (irq_counter == 0)
                            irq_counter = irq_latch + 8'd1;
                        irq_counter = irq_counter - 8'd1;
                        if (irq_counter == 0 && irq_on)
                            line_wait = LINE_TICKS;
                    end
                    filter_left = FILTER_TICKS;
                end
                prev_a12 = r.address[12];
                if (r.address[13])
                begin
                    ans.addr = {8'd0, (mirror_sel ? r.address[11] : r.address[10]),
                                r.address[9:0]};
                    ans.tgt  = TGT_NT;
                end
                else if (r.operation == OP_PPU_READ)
                begin
                    if (!r.address[12])
                        ans.addr = {chr_bank[r.address[11]], r.address[10:0]};
                    else
                        ans.addr = {1'b0, chr_bank[2 + int'(r.address[11:10])],
                                    r.address[9:0]};
                    ans.tgt = TGT_CHR;
                end
            end
            default: ;  // undefined operations leave everything alone
        endcase
        ans.irq = irq_out;
        awaited.push_back(ans);
    endtask

    task automatic queue_item(input logic [2:0] op, input logic [15:0] a, input logic [7:0] d);
        pending_t p;
        p.req   = '{operation: op, address: a, data: d};
        p.drain = drain_next;
        drain_next = 1'b0;
        pending.push_back(p);
    endtask

    // ------------------------------------------------------------------
    // Request driver: holds a stalled request, inserts idle bursts, and
    // waits for a full drain before any request so flagged.
    // ------------------------------------------------------------------
    req_t on_bus;
    bit   took;
    int   idle_left = 0;
    pending_t next_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_valid <= 1'b0;
        end
        else
        begin
            took = request_valid && !request_stall;
            if (took)
            begin
                map_bus_event(on_bus);
                n_sent <= n_sent + 1;
            end
            if (request_valid && !took)
                ;   // stalled: request stays on the bus unchanged
            else if (idle_left > 0)
            begin
                idle_left--;
                request_valid <= 1'b0;
            end
            else if (pending.size() == 0 ||
                     (pending[0].drain && (n_sent + int'(took) - n_seen) != 0))
                request_valid <= 1'b0;
            else
            begin
                next_item = pending.pop_front();
                on_bus = next_item.req;
                operation     <= next_item.req.operation;
                address       <= next_item.req.address;
                data          <= next_item.req.data;
                request_valid <= 1'b1;
                n_launched++;
                if (n_launched < quiet_from && $urandom_range(0, 7) == 0)
                    idle_left = $urandom_range(1, 6);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each result against the oldest expectation
    // and drives result_stall in bursts, with one long hold-off so the
    // block backs up into request_stall.
    // ------------------------------------------------------------------
    int      stall_left = 0;
    bit      long_done  = 1'b0;
    answer_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited.size() == 0)
                    report_mismatch($sformatf("result with nothing awaited (addr %h)",
                                              mapped_address));
                else
                begin
                    want = awaited.pop_front();
                    if (mapped_address !== want.addr)
                        report_mismatch($sformatf("request %0d mapped_address %h, want %h",
                                                  n_seen, mapped_address, want.addr));
                    if (target !== want.tgt)
                        report_mismatch($sformatf("request %0d target %0d, want %0d",
                                                  n_seen, target, want.tgt));
                    if (irq_line !== want.irq)
                        report_mismatch($sformatf("request %0d irq_line %b, want %b",
                                                  n_seen, irq_line, want.irq));
                end
                n_seen <= n_seen + 1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!long_done && n_seen >= 150)
            begin
                long_done  = 1'b1;
                stall_left = LONG_HOLD - 1;
                result_stall <= 1'b1;
            end
            else if (n_seen < quiet_from && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // watchdog: too long with neither channel moving
    int stuck = 0;

    always @(posedge clk)
    begin
        if ((request_valid && !request_stall) || (result_valid && !result_stall))
            stuck <= 0;
        else if (stuck >= STUCK_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stuck <= stuck + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int          pick;
        int          sel;
        int          marks;
        logic [15:0] a;
        logic [7:0]  d;

        // directed: field extremes, every operation and the corner cases
        queue_item(OP_CPU_READ,  16'h0000, 8'hff);     // pass-through below 0x8000
        queue_item(OP_CPU_READ,  16'h7fff, 8'h00);
        queue_item(OP_CPU_WRITE, 16'h8000, 8'hff);     // program bank masked to 6 bits
        queue_item(OP_CPU_WRITE, 16'h8001, 8'ha5);
        queue_item(OP_CPU_WRITE, 16'h8002, 8'hff);
        queue_item(OP_CPU_WRITE, 16'h8003, 8'h81);
        queue_item(OP_CPU_WRITE, 16'ha000, 8'h7e);
        queue_item(OP_CPU_WRITE, 16'ha001, 8'hc3);
        queue_item(OP_CPU_WRITE, 16'ha002, 8'h3c);
        queue_item(OP_CPU_WRITE, 16'ha003, 8'hff);
        queue_item(OP_CPU_WRITE, 16'he000, 8'h40);     // mirroring bit
        queue_item(OP_CPU_WRITE, 16'h7fff, 8'hff);     // below 0x8000: ignored
        queue_item(OP_CPU_WRITE, 16'hffff, 8'hff);     // unused decode
        queue_item(OP_CPU_READ,  16'h8000, 8'h00);
        queue_item(OP_CPU_READ,  16'hbfff, 8'h00);
        queue_item(OP_CPU_READ,  16'hc000, 8'h00);     // fixed banks
        queue_item(OP_CPU_READ,  16'hffff, 8'hff);
        queue_item(OP_PPU_READ,  16'h0000, 8'h00);
        queue_item(OP_PPU_READ,  16'h0fff, 8'h00);
        queue_item(OP_PPU_READ,  16'h1fff, 8'h00);     // A12 edge
        queue_item(OP_PPU_WRITE, 16'h0800, 8'hff);     // character ROM write: no effect
        queue_item(OP_PPU_READ,  16'h2fff, 8'h00);     // nametable
        queue_item(OP_PPU_WRITE, 16'hffff, 8'hff);     // above 0x3fff, inside filter window
        queue_item(OP_TICK,      16'hffff, 8'hff);
        queue_item(3'd7,         16'hffff, 8'hff);     // undefined operation
        queue_item(OP_CPU_WRITE, 16'hc000, 8'h00);     // reload value 0xff wraps on reload
        queue_item(OP_CPU_WRITE, 16'hc003, 8'h00);     // disable

        // random: mostly scanline-shaped traffic so the counter really fires
        drain_next = 1'b1;
        marks      = 1;
        while (pending.size() < RANDOM_ITEMS + 27)
        begin
            if (pending.size() >= 27 + 200 * marks)
            begin
                drain_next = 1'b1;   // pause until everything is back
                marks++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // one scanline: A12 low fetch, A12 high fetch, then some ticks
                a = 16'($urandom_range(0, 16'h3fff)) & ~16'h1000;
                queue_item($urandom_range(0, 1) ? OP_PPU_READ : OP_PPU_WRITE, a,
                           8'($urandom));
                a = 16'($urandom_range(0, 16'h3fff)) | 16'h1000;
                queue_item(OP_PPU_READ, a, 8'($urandom));
                repeat ($urandom_range(3, 9))
                    queue_item(OP_TICK, 16'($urandom), 8'($urandom));
            end
            else if (pick < 55)
            begin
                // bank, IRQ or mirroring write; selector 13..15 hits unused decodes
                sel = $urandom_range(0, 15);
                a   = 16'($urandom);
                a[15]    = 1'b1;
                a[14:13] = sel[3:2];
                a[1:0]   = sel[1:0];
                d = (sel == 8 && $urandom_range(0, 1)) ? 8'($urandom_range(8'hf8, 8'hff))
                                                       : 8'($urandom);
                queue_item(OP_CPU_WRITE, a, d);
            end
            else if (pick < 65)
            begin
                // IRQ control: clear, enable or disable
                sel = $urandom_range(0, 5);
                a   = 16'($urandom);
                a[15:13] = 3'b110;
                a[1:0]   = (sel < 2) ? 2'd1 : (sel < 5) ? 2'd2 : 2'd3;
                queue_item(OP_CPU_WRITE, a, 8'($urandom));
            end
            else if (pick < 80)
                queue_item(OP_CPU_READ, 16'($urandom), 8'($urandom));
            else if (pick < 90)
                queue_item($urandom_range(0, 1) ? OP_PPU_READ : OP_PPU_WRITE,
                           16'($urandom), 8'($urandom));
            else if (pick < 95)
                repeat ($urandom_range(1, 8))
                    queue_item(OP_TICK, 16'($urandom), 8'($urandom));
            else
                queue_item($urandom_range(0, 1) ? 3'($urandom_range(5, 7)) : OP_CPU_WRITE,
                           16'($urandom_range(0, 16'h7fff)), 8'($urandom));
        end
        quiet_from = pending.size() - QUIET_ITEMS;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || n_sent != n_launched || n_seen != n_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (awaited.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited.size()));
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
